// ----- hdl/bti_pkg.sv -----
// Shared types and constants for the binary trie key inserter.
`default_nettype none
package bti_pkg;

  localparam int NODE_DEPTH   = 262144;
  localparam int RECORD_DEPTH = 4096;
  localparam int NODE_W       = $clog2(NODE_DEPTH);
  localparam int CNT_W        = NODE_W + 1;
  localparam int KEY_W        = 8;
  localparam int REC_W        = 12;
  localparam int ADDED_W      = 4;
  localparam int TOP_BIT      = KEY_W - 1;
  localparam int BIT_W        = $clog2(KEY_W);

  typedef logic [NODE_W-1:0] node_idx_t;

  // One node store entry: leaf slot plus both child links; link 0 means empty.
  typedef struct packed {
    logic             leaf_valid;
    logic [REC_W-1:0] leaf_rec;
    node_idx_t        one;
    node_idx_t        zero;
  } node_word_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_WALK,
    ST_LOOK,
    ST_END,
    ST_LEAF,
    ST_EMIT
  } bti_state_t;

  typedef struct packed {
    logic init_root;
    logic load;
    logic rd_cur;
    logic step_fresh;
    logic step_look;
    logic finish_fresh;
    logic leaf_rmw;
    logic emit;
  } bti_cmd_t;

  typedef struct packed {
    logic broken;
    logic cur_fresh;
    logic bit_zero;
    logic need_leaf;
    logic out_free;
  } bti_status_t;

endpackage
`default_nettype wire

// ----- hdl/bti_key_if.sv -----
// Input channel: one key byte per transaction.
`default_nettype none
interface bti_key_if;
  import bti_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_byte;
  logic             last_byte;
  logic [REC_W-1:0] record_index;

  modport source (output valid, key_byte, last_byte, record_index, input ready);
  modport sink   (input valid, key_byte, last_byte, record_index, output ready);
endinterface
`default_nettype wire

// ----- hdl/bti_result_if.sv -----
// Result channel: one walk report per transaction.
`default_nettype none
interface bti_result_if;
  import bti_pkg::*;

  logic               valid;
  logic               ready;
  node_idx_t          end_node;
  logic [ADDED_W-1:0] nodes_added;
  logic               overflow;
  logic [CNT_W-1:0]   nodes_in_use;

  modport source (output valid, end_node, nodes_added, overflow, nodes_in_use, input ready);
  modport sink   (input valid, end_node, nodes_added, overflow, nodes_in_use, output ready);
endinterface
`default_nettype wire

// ----- hdl/bti_datapath.sv -----
// Node store, walk registers, allocator and result register.
`default_nettype none
module bti_datapath import bti_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  bti_cmd_t           cmd,
  output bti_status_t        status,
  input  logic [KEY_W-1:0]   key_byte,
  input  logic               last_byte,
  input  logic [REC_W-1:0]   record_index,
  output logic               out_valid,
  input  logic               out_ready,
  output node_idx_t          end_node,
  output logic [ADDED_W-1:0] nodes_added,
  output logic               overflow,
  output logic [CNT_W-1:0]   nodes_in_use
);

  node_word_t         mem [NODE_DEPTH];
  node_word_t         rd_word;

  logic [KEY_W-1:0]   key;
  logic               last;
  logic [REC_W-1:0]   rec;
  node_idx_t          cur;
  node_idx_t          cursor;
  logic               cur_fresh;
  logic               full;
  logic               broken;
  logic [CNT_W-1:0]   count;
  logic [ADDED_W-1:0] added;
  logic [BIT_W-1:0]   bit_idx;

  logic               step;
  node_word_t         w;
  node_idx_t          link;
  logic               link_empty;
  logic               store_out;
  logic               alloc;
  logic               rec_ok;
  logic               need_leaf;

  logic               wr_en;
  node_idx_t          wr_addr;
  node_word_t         wr_data;

  always_comb begin
    step       = cmd.step_fresh | cmd.step_look;
    // a node allocated during this walk has not been written yet: its links are empty
    w          = cmd.step_fresh ? '0 : rd_word;
    link       = key[bit_idx] ? w.one : w.zero;
    link_empty = (link == '0);
    store_out  = (count >= CNT_W'(NODE_DEPTH));
    alloc      = step && link_empty && !store_out;
    rec_ok     = (32'(rec) < 32'(RECORD_DEPTH));
    need_leaf  = last && !broken && rec_ok;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur;
    wr_data = w;
    if (cmd.init_root) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = '0;
    end else if (alloc) begin
      wr_en = 1'b1;
      if (key[bit_idx]) begin
        wr_data.one = count[NODE_W-1:0];
      end else begin
        wr_data.zero = count[NODE_W-1:0];
      end
    end else if (cmd.finish_fresh) begin
      // fresh node ends the byte: clear it, with the leaf if this key ends here
      wr_en   = 1'b1;
      wr_data = '0;
      if (need_leaf) begin
        wr_data.leaf_valid = 1'b1;
        wr_data.leaf_rec   = rec;
      end
    end else if (cmd.leaf_rmw) begin
      wr_en              = 1'b1;
      wr_data            = rd_word;
      wr_data.leaf_valid = 1'b1;
      wr_data.leaf_rec   = rec;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_cur) begin
      rd_word <= mem[cur];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor    <= '0;
      full      <= 1'b0;
      broken    <= 1'b0;
      count     <= CNT_W'(1);
      cur_fresh <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load || cmd.finish_fresh) begin
        cur_fresh <= 1'b0;
      end
      if (step) begin
        if (!link_empty) begin
          cur_fresh <= 1'b0;
        end else if (store_out) begin
          full   <= 1'b1;
          broken <= 1'b1;
        end else begin
          count     <= count + CNT_W'(1);
          cur_fresh <= 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (last) begin
          cursor <= '0;
          broken <= 1'b0;
        end else begin
          cursor <= cur;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walk payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key     <= key_byte;
      last    <= last_byte;
      rec     <= record_index;
      cur     <= cursor;
      added   <= '0;
      bit_idx <= BIT_W'(TOP_BIT);
    end
    if (step) begin
      bit_idx <= bit_idx - BIT_W'(1);
      if (!link_empty) begin
        cur <= link;
      end else if (!store_out) begin
        cur   <= count[NODE_W-1:0];
        added <= added + ADDED_W'(1);
      end
    end
    if (cmd.emit) begin
      end_node     <= cur;
      nodes_added  <= added;
      overflow     <= full;
      nodes_in_use <= count;
    end
  end

  always_comb begin
    status.broken    = broken;
    status.cur_fresh = cur_fresh;
    status.bit_zero  = (bit_idx == '0);
    status.need_leaf = need_leaf;
    status.out_free  = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

// ----- hdl/bti_controller.sv -----
// Sequencer for the per-bit trie walk and leaf update.
`default_nettype none
module bti_controller import bti_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  bti_status_t status,
  output bti_cmd_t    cmd
);

  bti_state_t state;
  bti_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_INIT: begin
        cmd.init_root = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (status.broken) begin
          state_next = ST_END;
        end else if (status.cur_fresh) begin
          cmd.step_fresh = 1'b1;
          state_next     = status.bit_zero ? ST_END : ST_WALK;
        end else begin
          cmd.rd_cur = 1'b1;
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.step_look = 1'b1;
        state_next    = status.bit_zero ? ST_END : ST_WALK;
      end
      ST_END: begin
        if (status.cur_fresh) begin
          cmd.finish_fresh = 1'b1;
          state_next       = ST_EMIT;
        end else if (status.need_leaf) begin
          cmd.rd_cur = 1'b1;
          state_next = ST_LEAF;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_LEAF: begin
        cmd.leaf_rmw = 1'b1;
        state_next   = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/binary_trie_key_insert_core.sv -----
// Top level of the binary trie key inserter.
`default_nettype none
// Each key_in transaction walks one key byte, bit 7 first, through a node store
// of NODE_DEPTH entries, allocating nodes in order as links turn out empty; the
// final byte of a key, unless the key overflowed, stores its record index as the
// leaf of the node reached. One byte is handled at a time: the node store has a
// single registered read port, so each bit below an existing node takes a read
// state (WALK) and a decide state (LOOK), each bit below a node just allocated is
// decided in WALK alone, and ending on an existing node adds a read-modify-write
// of its leaf. Bytes of a key that already overflowed skip the bit steps. The result
// register lets the next byte be accepted while a result waits. After reset the
// block clears the root in its INIT state before it takes input.
module binary_trie_key_insert_core import bti_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  bti_key_if.sink      key_in,
  bti_result_if.source result
);

  bti_cmd_t    cmd;
  bti_status_t status;

  bti_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (key_in.valid),
    .in_ready (key_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  bti_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .key_byte     (key_in.key_byte),
    .last_byte    (key_in.last_byte),
    .record_index (key_in.record_index),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .end_node     (result.end_node),
    .nodes_added  (result.nodes_added),
    .overflow     (result.overflow),
    .nodes_in_use (result.nodes_in_use)
  );

endmodule
`default_nettype wire

// ----- hdl/bti_checker.sv -----
// Port-level assertions for the trie inserter, bound to the top level.
`default_nettype none
module bti_checker import bti_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input node_idx_t          end_node,
  input logic [ADDED_W-1:0] nodes_added,
  input logic               overflow,
  input logic [CNT_W-1:0]   nodes_in_use
);

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(end_node) && $stable(nodes_added)
      && $stable(overflow) && $stable(nodes_in_use))
    else $error("result changed while stalled");

  // one byte in flight: no back-to-back input transactions
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a byte is in flight");

  a_counts_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> nodes_added <= ADDED_W'(KEY_W) && nodes_in_use != '0
      && nodes_in_use <= CNT_W'(NODE_DEPTH))
    else $error("result counts out of range");

  // overflow is only reported once every node is in use
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> nodes_in_use == CNT_W'(NODE_DEPTH))
    else $error("overflow with free nodes left");

endmodule

bind binary_trie_key_insert_core bti_checker u_bti_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (key_in.valid),
  .in_ready     (key_in.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .end_node     (result.end_node),
  .nodes_added  (result.nodes_added),
  .overflow     (result.overflow),
  .nodes_in_use (result.nodes_in_use)
);
`default_nettype wire
